@@ hw/rtl/vector2d_normalizer_macros.svh @@
// Assertion macros for the vector normalizer RTL.
// Used by the top level; no other dependencies.
`ifndef VECTOR2D_NORMALIZER_MACROS_SVH
`define VECTOR2D_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define VN_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("vector normalizer same-cycle check failed");
`define VN_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("vector normalizer next-cycle check failed");
`else
`define VN_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define VN_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ hw/rtl/vnorm_pkg.sv @@
// Package for the vector normalizer: widths, stage counts and payload types.
// No dependencies.
package vnorm_pkg;
    localparam int IN_WIDTH  = 16;
    localparam int FRAC_OUT  = 14;
    localparam int MAG_W     = IN_WIDTH + 1;
    localparam int SUM_W     = 2 * IN_WIDTH;
    localparam int RAD_W     = 64;
    localparam int LEN_W     = 32;
    localparam int SQRT_N    = 32;
    localparam int Q_W       = FRAC_OUT + 1;
    localparam int NUM_SHIFT = FRAC_OUT + 32 - IN_WIDTH;
    localparam int REM_W     = MAG_W + NUM_SHIFT;

    typedef struct packed {
        logic signed [15:0] x_in;
        logic signed [15:0] y_in;
    } vec_t;

    typedef struct packed {
        logic signed [15:0] x_unit;
        logic signed [15:0] y_unit;
        logic               zero_length;
    } unit_t;

    // Per-item data that rides along the pipeline.
    typedef struct packed {
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic             nx;
        logic             ny;
        logic             zero;
    } side_t;
endpackage

@@ hw/rtl/vnorm_sqrt.sv @@
// Pipelined integer square root, one bit of root per stage.
// Depends on vnorm_pkg.
module vnorm_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid,
    input  logic [vnorm_pkg::SUM_W-1:0]    sum,
    input  vnorm_pkg::side_t               side,
    output logic                           root_valid,
    output logic [vnorm_pkg::LEN_W-1:0]    root,
    output vnorm_pkg::side_t               root_side
);
    localparam int N = vnorm_pkg::SQRT_N;

    logic [vnorm_pkg::RAD_W-1:0] rem_reg [N];
    logic [vnorm_pkg::RAD_W-1:0] res_reg [N];
    vnorm_pkg::side_t            side_reg [N];
    logic                        vld_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic [vnorm_pkg::RAD_W-1:0] BIT_C =
            vnorm_pkg::RAD_W'(64'd1 << (62 - 2 * i));
        logic [vnorm_pkg::RAD_W-1:0] rem_cur;
        logic [vnorm_pkg::RAD_W-1:0] res_cur;
        vnorm_pkg::side_t            side_cur;
        logic                        vld_cur;
        logic [vnorm_pkg::RAD_W-1:0] trial;
        logic [vnorm_pkg::RAD_W-1:0] rem_next;
        logic [vnorm_pkg::RAD_W-1:0] res_next;

        if (i == 0)
        begin : g_first
            // The radicand is the sum shifted up 32 bits.
            assign rem_cur  = {sum, {(vnorm_pkg::RAD_W - vnorm_pkg::SUM_W){1'b0}}};
            assign res_cur  = '0;
            assign side_cur = side;
            assign vld_cur  = valid;
        end
        else
        begin : g_next
            assign rem_cur  = rem_reg[i-1];
            assign res_cur  = res_reg[i-1];
            assign side_cur = side_reg[i-1];
            assign vld_cur  = vld_reg[i-1];
        end

        always_comb
        begin
            trial = res_cur + BIT_C;
            if (rem_cur >= trial)
            begin
                rem_next = rem_cur - trial;
                res_next = (res_cur >> 1) + BIT_C;
            end
            else
            begin
                rem_next = rem_cur;
                res_next = res_cur >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                res_reg[i]  <= res_next;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign root_valid = vld_reg[N-1];
    assign root       = res_reg[N-1][vnorm_pkg::LEN_W-1:0];
    assign root_side  = side_reg[N-1];
endmodule

@@ hw/rtl/vnorm_div.sv @@
// Pipelined restoring divider for both components, one quotient bit per stage.
// Depends on vnorm_pkg.
module vnorm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid,
    input  logic [vnorm_pkg::LEN_W-1:0]    len,
    input  vnorm_pkg::side_t               side,
    output logic                           q_valid,
    output logic [vnorm_pkg::Q_W-1:0]      qx,
    output logic [vnorm_pkg::Q_W-1:0]      qy,
    output vnorm_pkg::side_t               q_side
);
    localparam int N = vnorm_pkg::Q_W;
    localparam int RW = vnorm_pkg::REM_W;

    logic [RW-1:0]               rx_reg [N];
    logic [RW-1:0]               ry_reg [N];
    logic [N-1:0]                qx_reg [N];
    logic [N-1:0]                qy_reg [N];
    logic [vnorm_pkg::LEN_W-1:0] len_reg [N];
    vnorm_pkg::side_t            side_reg [N];
    logic                        vld_reg [N];

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        localparam int K = N - 1 - j;
        logic [RW-1:0]               rx_cur;
        logic [RW-1:0]               ry_cur;
        logic [N-1:0]                qx_cur;
        logic [N-1:0]                qy_cur;
        logic [vnorm_pkg::LEN_W-1:0] len_cur;
        vnorm_pkg::side_t            side_cur;
        logic                        vld_cur;
        logic [RW-1:0]               dsh;
        logic [RW-1:0]               rx_next;
        logic [RW-1:0]               ry_next;
        logic [N-1:0]                qx_next;
        logic [N-1:0]                qy_next;

        if (j == 0)
        begin : g_first
            assign rx_cur   = {side.ax, {vnorm_pkg::NUM_SHIFT{1'b0}}};
            assign ry_cur   = {side.ay, {vnorm_pkg::NUM_SHIFT{1'b0}}};
            assign qx_cur   = '0;
            assign qy_cur   = '0;
            assign len_cur  = len;
            assign side_cur = side;
            assign vld_cur  = valid;
        end
        else
        begin : g_next
            assign rx_cur   = rx_reg[j-1];
            assign ry_cur   = ry_reg[j-1];
            assign qx_cur   = qx_reg[j-1];
            assign qy_cur   = qy_reg[j-1];
            assign len_cur  = len_reg[j-1];
            assign side_cur = side_reg[j-1];
            assign vld_cur  = vld_reg[j-1];
        end

        always_comb
        begin
            dsh     = RW'(len_cur) << K;
            rx_next = rx_cur;
            ry_next = ry_cur;
            qx_next = qx_cur;
            qy_next = qy_cur;
            if (rx_cur >= dsh)
            begin
                rx_next    = rx_cur - dsh;
                qx_next[K] = 1'b1;
            end
            if (ry_cur >= dsh)
            begin
                ry_next    = ry_cur - dsh;
                qy_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[j]   <= rx_next;
                ry_reg[j]   <= ry_next;
                qx_reg[j]   <= qx_next;
                qy_reg[j]   <= qy_next;
                len_reg[j]  <= len_cur;
                side_reg[j] <= side_cur;
            end
        end
    end

    assign q_valid = vld_reg[N-1];
    assign qx      = qx_reg[N-1];
    assign qy      = qy_reg[N-1];
    assign q_side  = side_reg[N-1];
endmodule

@@ hw/rtl/vector2d_normalizer.sv @@
// Vector normalizer: Q8.8 vector in, Q1.14 unit vector out.
// Uses vnorm_pkg, vnorm_sqrt, vnorm_div and vector2d_normalizer_macros.svh.
//
// Usage:
//   Input channel vec_valid/vec_ready/vec carries one vector per transaction
//   (x_in, y_in, signed Q8.8). Output channel unit_valid/unit_ready/unit
//   carries one result per transaction (x_unit, y_unit in signed Q1.14 and
//   zero_length). Every input gives exactly one result, in order.
//   From acceptance to output a vector passes one input register, one
//   squaring stage, 32 square root stages (one root bit each), 15 divider
//   stages (one quotient bit each) and the output register.
//   Throughput is one transaction per cycle while unit_ready does not stall
//   the output; every stage is a register slice that takes a new vector each
//   cycle in which the pipeline is not frozen.
//   A zero vector gives zero components with zero_length set.
//   Results are truncated toward zero.
//   Reset clears all valid bits; the pipeline is empty and vec_ready is high.
//   When the receiver holds unit_ready low with a result waiting, the whole
//   pipeline freezes and vec_ready drops in the same cycle; nothing is lost.
`include "vector2d_normalizer_macros.svh"
module vector2d_normalizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vec_valid,
    output logic              vec_ready,
    input  vnorm_pkg::vec_t   vec,
    output logic              unit_valid,
    input  logic              unit_ready,
    output vnorm_pkg::unit_t  unit
);
    logic en;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    vnorm_pkg::side_t s1_side_reg;
    vnorm_pkg::side_t s2_side_reg;
    logic [vnorm_pkg::SUM_W-1:0] sum_reg;
    vnorm_pkg::side_t side_next;
    logic [vnorm_pkg::SUM_W-1:0] sum_next;
    vnorm_pkg::unit_t unit_reg;
    vnorm_pkg::unit_t unit_next;

    logic                        root_valid;
    logic [vnorm_pkg::LEN_W-1:0] root;
    vnorm_pkg::side_t            root_side;
    logic                        q_valid;
    logic [vnorm_pkg::Q_W-1:0]   qx;
    logic [vnorm_pkg::Q_W-1:0]   qy;
    vnorm_pkg::side_t            q_side;

    assign en        = !out_valid_reg || unit_ready;
    assign vec_ready = en;

    // Sign and magnitude; the most negative input has magnitude 2^15.
    always_comb
    begin
        side_next.nx   = vec.x_in[15];
        side_next.ny   = vec.y_in[15];
        side_next.ax   = vec.x_in[15] ? (vnorm_pkg::MAG_W'(0) - {vec.x_in[15], vec.x_in})
                                      : {1'b0, vec.x_in};
        side_next.ay   = vec.y_in[15] ? (vnorm_pkg::MAG_W'(0) - {vec.y_in[15], vec.y_in})
                                      : {1'b0, vec.y_in};
        side_next.zero = (vec.x_in == '0) && (vec.y_in == '0);
    end

    assign sum_next = vnorm_pkg::SUM_W'(s1_side_reg.ax) * vnorm_pkg::SUM_W'(s1_side_reg.ax)
                    + vnorm_pkg::SUM_W'(s1_side_reg.ay) * vnorm_pkg::SUM_W'(s1_side_reg.ay);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= vec_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg <= side_next;
            s2_side_reg <= s1_side_reg;
            sum_reg     <= sum_next;
            unit_reg    <= unit_next;
        end
    end

    vnorm_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .valid      (s2_valid_reg),
        .sum        (sum_reg),
        .side       (s2_side_reg),
        .root_valid (root_valid),
        .root       (root),
        .root_side  (root_side)
    );

    vnorm_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid   (root_valid),
        .len     (root),
        .side    (root_side),
        .q_valid (q_valid),
        .qx      (qx),
        .qy      (qy),
        .q_side  (q_side)
    );

    // The quotient never exceeds 2^14, so it fits the signed output as is.
    always_comb
    begin
        unit_next.zero_length = q_side.zero;
        if (q_side.zero)
        begin
            unit_next.x_unit = '0;
            unit_next.y_unit = '0;
        end
        else
        begin
            unit_next.x_unit = q_side.nx ? (16'sd0 - 16'(qx)) : 16'(qx);
            unit_next.y_unit = q_side.ny ? (16'sd0 - 16'(qy)) : 16'(qy);
        end
    end

    assign unit_valid = out_valid_reg;
    assign unit       = unit_reg;

    `VN_ASSERT_SAME(a_zero_out, clk, rst_n, unit_valid && unit.zero_length,
        unit.x_unit == 16'sd0 && unit.y_unit == 16'sd0)
    `VN_ASSERT_SAME(a_unit_range, clk, rst_n, unit_valid,
        unit.x_unit <= 16'sd16384 && unit.x_unit >= -16'sd16384)
    `VN_ASSERT_NEXT(a_freeze, clk, rst_n, !vec_ready,
        $stable(sum_reg) && $stable(s2_valid_reg))
endmodule

@@ test/tb.sv @@
// Testbench for vector2d_normalizer: directed table then random vectors, checked in order.
// Depends on vnorm_pkg and the vector2d_normalizer RTL.
`timescale 1ns / 100ps
module tb;
    localparam int LATENCY = 50;
    localparam int N_RANDOM = 1630;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             vec_valid = 1'b0;
    logic             vec_ready;
    vnorm_pkg::vec_t  vec = '0;
    logic             unit_valid;
    logic             unit_ready = 1'b0;
    vnorm_pkg::unit_t unit;

    vnorm_pkg::unit_t expected_units[$];
    int    error_count = 0;
    bit    quiet_tail = 1'b0;

    vector2d_normalizer u_dut (
        .clk(clk), .rst_n(rst_n), .vec_valid(vec_valid), .vec_ready(vec_ready),
        .vec(vec), .unit_valid(unit_valid), .unit_ready(unit_ready), .unit(unit)
    );

    always #6 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [63:0] root_of(logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] scale_component(logic [16:0] mag, logic neg,
                                                    logic [63:0] len);
        logic [63:0] q;
        q = ({47'd0, mag} << vnorm_pkg::NUM_SHIFT) / len;
        if (neg)
        begin
            if (q > 64'd32768)
                q = 64'd32768;
            q = -q;
        end
        else if (q > 64'd32767)
            q = 64'd32767;
        return q[15:0];
    endfunction

    function automatic vnorm_pkg::unit_t normalize(vnorm_pkg::vec_t v);
        vnorm_pkg::unit_t r;
        logic [16:0] ax;
        logic [16:0] ay;
        logic [63:0] sum;
        logic [63:0] len;
        ax = v.x_in < 0 ? 17'(-int'(v.x_in)) : 17'(v.x_in);
        ay = v.y_in < 0 ? 17'(-int'(v.y_in)) : 17'(v.y_in);
        sum = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        r = '0;
        if (sum == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        len = root_of(sum << (2 * (32 - vnorm_pkg::IN_WIDTH)));
        r.x_unit = scale_component(ax, v.x_in < 0, len);
        r.y_unit = scale_component(ay, v.y_in < 0, len);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Sender gap, drawn per transaction; valid drops only for a gap.
    task automatic sender_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            vec_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_vector(vnorm_pkg::vec_t v, bit has_golden, vnorm_pkg::unit_t golden);
        sender_gap();
        vec <= v;
        vec_valid <= 1'b1;
        expected_units.push_back(has_golden ? golden : normalize(v));
        do @(posedge clk); while (!vec_ready);
    endtask

    // Receiver stalls in bursts, the transaction is checked at the accepting edge.
    initial
    begin
        int stall;
        vnorm_pkg::unit_t want;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (unit_valid && unit_ready)
            begin
                if (expected_units.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = expected_units.pop_front();
                    if (unit.x_unit !== want.x_unit)
                        report_mismatch("x_unit", unit.x_unit, want.x_unit);
                    if (unit.y_unit !== want.y_unit)
                        report_mismatch("y_unit", unit.y_unit, want.y_unit);
                    if (unit.zero_length !== want.zero_length)
                        report_mismatch("zero_length", unit.zero_length, want.zero_length);
                end
            end
            if (stall > 0)
                stall--;
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 13);
            unit_ready <= (stall == 0) && rst_n;
        end
    end

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic               zl;
    } stim_row_t;

    stim_row_t stim_rows[] = '{
        '{16'sd0,      16'sd0,      1, 16'sd0,      16'sd0,      1'b1},
        '{16'sd256,    16'sd0,      1, 16'sd16384,  16'sd0,      1'b0},
        '{-16'sd256,   16'sd0,      1, -16'sd16384, 16'sd0,      1'b0},
        '{16'sd0,      16'sd1,      1, 16'sd0,      16'sd16384,  1'b0},
        '{16'sd0,      -16'sd1,     1, 16'sd0,      -16'sd16384, 1'b0},
        '{16'sd32767,  16'sd0,      1, 16'sd16384,  16'sd0,      1'b0},
        '{-16'sd32768, 16'sd0,      1, -16'sd16384, 16'sd0,      1'b0},
        '{16'sd0,      -16'sd32768, 1, 16'sd0,      -16'sd16384, 1'b0},
        '{-16'sd32768, -16'sd32768, 0, 16'sd0,      16'sd0,      1'b0},
        '{16'sd32767,  16'sd32767,  0, 16'sd0,      16'sd0,      1'b0},
        '{-16'sd32768, 16'sd32767,  0, 16'sd0,      16'sd0,      1'b0},
        '{16'sd1,      16'sd1,      0, 16'sd0,      16'sd0,      1'b0},
        '{-16'sd1,     16'sd1,      0, 16'sd0,      16'sd0,      1'b0},
        '{16'sd3,      -16'sd4,     0, 16'sd0,      16'sd0,      1'b0},
        '{16'sd1,      16'sd32767,  0, 16'sd0,      16'sd0,      1'b0},
        '{-16'sd21846, 16'sd12345,  0, 16'sd0,      16'sd0,      1'b0},
        '{16'sd21845,  -16'sd10922, 0, 16'sd0,      16'sd0,      1'b0}
    };

    initial
    begin
        vnorm_pkg::vec_t  v;
        vnorm_pkg::unit_t g;
        int    t;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_rows[i])
        begin
            v.x_in = stim_rows[i].x;
            v.y_in = stim_rows[i].y;
            g.x_unit = stim_rows[i].ux;
            g.y_unit = stim_rows[i].uy;
            g.zero_length = stim_rows[i].zl;
            send_vector(v, stim_rows[i].typed, g);
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 150)
                quiet_tail = 1'b1;
            case ($urandom_range(0, 4))
                0: v = vnorm_pkg::vec_t'($urandom);
                1:
                begin
                    // Small magnitudes exercise coarse roots.
                    v.x_in = 16'($signed($urandom_range(0, 16)) - 8);
                    v.y_in = 16'($signed($urandom_range(0, 16)) - 8);
                end
                2:
                begin
                    v.x_in = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    v.y_in = 16'($urandom);
                end
                3:
                begin
                    v.x_in = 16'($urandom);
                    v.y_in = 16'($urandom_range(0, 3) == 0 ? 0 : $urandom);
                end
                default: v = vnorm_pkg::vec_t'($urandom);
            endcase
            send_vector(v, 0, g);
        end
        vec_valid <= 1'b0;
        t = 0;
        while (expected_units.size() != 0 && t < 100000)
        begin
            @(posedge clk);
            t++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && expected_units.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
